@@ hdl/sgg_pkg.sv @@
// Shared types, constants and functions of the stochastic grid grower.
package sgg_pkg;

  localparam int DEF_SIZE_X = 32;
  localparam int DEF_SIZE_Y = 32;
  localparam int DEF_SIZE_Z = 32;
  localparam int NEIGHBOURS = 26;
  localparam int NB_W       = 5;
  localparam int PROB_W     = 10;
  localparam int COORD_W    = 5;
  localparam int COUNT_W    = 16;

  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_SEED      = 3'd0;
  localparam logic [2:0] REG_CORE_THR  = 3'd1;
  localparam logic [2:0] REG_TARGET    = 3'd2;
  localparam logic [2:0] REG_DIR_0     = 3'd3;
  localparam logic [2:0] REG_DIR_1     = 3'd4;
  localparam logic [2:0] REG_DIR_2     = 3'd5;
  localparam logic [2:0] REG_DIR_3     = 3'd6;
  localparam logic [2:0] REG_DIR_4     = 3'd7;

  typedef enum logic [1:0] {
    ACT_GEN  = 2'd0,
    ACT_GROW = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OFF_ZERO = 2'd0,
    OFF_POS  = 2'd1,
    OFF_NEG  = 2'd2,
    OFF_NONE = 2'd3
  } off_t;

  typedef struct packed {
    off_t dx;
    off_t dy;
    off_t dz;
  } nb_off_t;

  typedef struct packed {
    logic [31:0]                        seed;
    logic [15:0]                        core_threshold;
    logic [15:0]                        target_count;
    logic [NEIGHBOURS-1:0][PROB_W-1:0]  dir_prob;
  } cfg_t;

  typedef struct packed {
    action_t            action;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
  } cmd_t;

  typedef struct packed {
    logic               cell_value;
    logic [COUNT_W-1:0] filled_count;
    logic               target_reached;
  } res_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] n;
    n = {1'b0, s[31:1]};
    if (s[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

  // Offsets of the 26 neighbours, in visiting order.
  function automatic nb_off_t nb_offset(input logic [NB_W-1:0] i);
    nb_off_t o;
    unique case (i)
      5'd0:  o = '{OFF_ZERO, OFF_ZERO, OFF_POS};
      5'd1:  o = '{OFF_ZERO, OFF_ZERO, OFF_NEG};
      5'd2:  o = '{OFF_POS,  OFF_ZERO, OFF_ZERO};
      5'd3:  o = '{OFF_NEG,  OFF_ZERO, OFF_ZERO};
      5'd4:  o = '{OFF_ZERO, OFF_POS,  OFF_ZERO};
      5'd5:  o = '{OFF_ZERO, OFF_NEG,  OFF_ZERO};
      5'd6:  o = '{OFF_POS,  OFF_ZERO, OFF_POS};
      5'd7:  o = '{OFF_NEG,  OFF_ZERO, OFF_POS};
      5'd8:  o = '{OFF_ZERO, OFF_POS,  OFF_POS};
      5'd9:  o = '{OFF_ZERO, OFF_NEG,  OFF_POS};
      5'd10: o = '{OFF_POS,  OFF_ZERO, OFF_NEG};
      5'd11: o = '{OFF_NEG,  OFF_ZERO, OFF_NEG};
      5'd12: o = '{OFF_ZERO, OFF_POS,  OFF_NEG};
      5'd13: o = '{OFF_ZERO, OFF_NEG,  OFF_NEG};
      5'd14: o = '{OFF_POS,  OFF_POS,  OFF_ZERO};
      5'd15: o = '{OFF_NEG,  OFF_NEG,  OFF_ZERO};
      5'd16: o = '{OFF_POS,  OFF_NEG,  OFF_ZERO};
      5'd17: o = '{OFF_NEG,  OFF_POS,  OFF_ZERO};
      5'd18: o = '{OFF_POS,  OFF_POS,  OFF_POS};
      5'd19: o = '{OFF_NEG,  OFF_NEG,  OFF_POS};
      5'd20: o = '{OFF_POS,  OFF_NEG,  OFF_POS};
      5'd21: o = '{OFF_NEG,  OFF_POS,  OFF_POS};
      5'd22: o = '{OFF_POS,  OFF_POS,  OFF_NEG};
      5'd23: o = '{OFF_NEG,  OFF_NEG,  OFF_NEG};
      5'd24: o = '{OFF_POS,  OFF_NEG,  OFF_NEG};
      5'd25: o = '{OFF_NEG,  OFF_POS,  OFF_NEG};
      default: o = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
    endcase
    return o;
  endfunction

  // Periodic step of one coordinate; lim is the size minus one.
  function automatic logic [7:0] wrap_step(input logic [7:0] c, input off_t d,
                                           input logic [7:0] lim);
    logic [7:0] r;
    unique case (d)
      OFF_POS: r = (c == lim) ? 8'd0 : c + 8'd1;
      OFF_NEG: r = (c == 8'd0) ? lim : c - 8'd1;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/sgg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module sgg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sgg_regs.sv @@
// APB-style configuration register file of the grid grower.
module sgg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output sgg_pkg::cfg_t cfg
);
  import sgg_pkg::*;

  logic [31:0]      seed_r;
  logic [15:0]      core_thr_r;
  logic [15:0]      target_r;
  logic [4:0][59:0] dir_word_r;
  logic [2:0]       idx;
  logic             wr;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= 32'd1;
      core_thr_r <= '0;
      target_r   <= '0;
      dir_word_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SEED:     seed_r        <= pwdata[31:0];
        REG_CORE_THR: core_thr_r    <= pwdata[15:0];
        REG_TARGET:   target_r      <= pwdata[15:0];
        REG_DIR_0:    dir_word_r[0] <= pwdata[59:0];
        REG_DIR_1:    dir_word_r[1] <= pwdata[59:0];
        REG_DIR_2:    dir_word_r[2] <= pwdata[59:0];
        REG_DIR_3:    dir_word_r[3] <= pwdata[59:0];
        REG_DIR_4:    dir_word_r[4] <= {40'd0, pwdata[19:0]};
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEED:     prdata = {32'd0, seed_r};
      REG_CORE_THR: prdata = {48'd0, core_thr_r};
      REG_TARGET:   prdata = {48'd0, target_r};
      REG_DIR_0:    prdata = {4'd0, dir_word_r[0]};
      REG_DIR_1:    prdata = {4'd0, dir_word_r[1]};
      REG_DIR_2:    prdata = {4'd0, dir_word_r[2]};
      REG_DIR_3:    prdata = {4'd0, dir_word_r[3]};
      REG_DIR_4:    prdata = {4'd0, dir_word_r[4]};
      default:      prdata = '0;
    endcase
  end

  assign cfg.seed           = seed_r;
  assign cfg.core_threshold = core_thr_r;
  assign cfg.target_count   = target_r;

  for (genvar i = 0; i < NEIGHBOURS; i++) begin : g_prob
    assign cfg.dir_prob[i] = dir_word_r[i / 6][10 * (i % 6) +: PROB_W];
  end

endmodule

@@ hdl/sgg_engine.sv @@
// Sequencer that generates and grows the structure in the grid and list memories.
module sgg_engine #(
  parameter int SIZE_X = sgg_pkg::DEF_SIZE_X,
  parameter int SIZE_Y = sgg_pkg::DEF_SIZE_Y,
  parameter int SIZE_Z = sgg_pkg::DEF_SIZE_Z
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sgg_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sgg_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output sgg_pkg::res_t res
);
  import sgg_pkg::*;

  localparam int XW    = $clog2(SIZE_X);
  localparam int YW    = $clog2(SIZE_Y);
  localparam int ZW    = $clog2(SIZE_Z);
  localparam int AW    = XW + YW + ZW;
  localparam int CELLS = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int KW    = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [7:0]    LIM_X     = 8'(SIZE_X - 1);
  localparam logic [7:0]    LIM_Y     = 8'(SIZE_Y - 1);
  localparam logic [7:0]    LIM_Z     = 8'(SIZE_Z - 1);
  localparam logic [CW-1:0] CELLS_C   = CW'(CELLS);
  localparam logic [NB_W-1:0] NB_LAST = NB_W'(NEIGHBOURS - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_GEN    = 8'b0000_0010,
    S_RD     = 8'b0000_0100,
    S_PASS   = 8'b0000_1000,
    S_LIST   = 8'b0001_0000,
    S_NB_RD  = 8'b0010_0000,
    S_NB_CHK = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      gx_r, gx_nxt, gy_r, gy_nxt, gz_r, gz_nxt;
  logic [7:0]      cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [AW-1:0]   na_r, na_nxt;
  logic [NB_W-1:0] nb_r, nb_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   pass_end_r, pass_end_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [31:0]     lfsr_r, lfsr_nxt;
  logic            cv_r, cv_nxt;

  logic            grid_we, grid_wdata, grid_rdata;
  logic [AW-1:0]   grid_waddr, grid_raddr;
  logic            list_we;
  logic [AW-1:0]   list_waddr, list_wdata, list_raddr, list_rdata;

  logic [31:0]     lf;
  logic [7:0]      rx, ry, rz, nx, ny, nz;
  logic            rd_in_range;
  nb_off_t         off;
  logic [KW-1:0]   total_k, target_k;
  logic            below_target;

  sgg_ram #(.WIDTH(1), .DEPTH(2 ** AW)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  sgg_ram #(.WIDTH(AW), .DEPTH(2 ** AW)) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  assign lf           = lfsr_step(lfsr_r);
  assign rx           = 8'(cmd.cell_x);
  assign ry           = 8'(cmd.cell_y);
  assign rz           = 8'(cmd.cell_z);
  assign rd_in_range  = (rx <= LIM_X) && (ry <= LIM_Y) && (rz <= LIM_Z);
  assign off          = nb_offset(nb_r);
  assign nx           = wrap_step(cx_r, off.dx, LIM_X);
  assign ny           = wrap_step(cy_r, off.dy, LIM_Y);
  assign nz           = wrap_step(cz_r, off.dz, LIM_Z);
  assign total_k      = KW'(total_r);
  assign target_k     = KW'(cfg.target_count);
  assign below_target = total_k < target_k;

  assign list_raddr = cursor_r[AW-1:0];

  always_comb begin
    state_nxt    = state_r;
    gx_nxt       = gx_r;
    gy_nxt       = gy_r;
    gz_nxt       = gz_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    cz_nxt       = cz_r;
    na_nxt       = na_r;
    nb_nxt       = nb_r;
    total_nxt    = total_r;
    pass_end_nxt = pass_end_r;
    cursor_nxt   = cursor_r;
    lfsr_nxt     = lfsr_r;
    cv_nxt       = cv_r;
    grid_we      = 1'b0;
    grid_waddr   = {gz_r[ZW-1:0], gy_r[YW-1:0], gx_r[XW-1:0]};
    grid_wdata   = 1'b0;
    grid_raddr   = {rz[ZW-1:0], ry[YW-1:0], rx[XW-1:0]};
    list_we      = 1'b0;
    list_waddr   = total_r[AW-1:0];
    list_wdata   = {gz_r[ZW-1:0], gy_r[YW-1:0], gx_r[XW-1:0]};

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cv_nxt = 1'b0;
          unique case (cmd.action)
            ACT_GEN: begin
              lfsr_nxt  = (cfg.seed == 32'd0) ? 32'd1 : cfg.seed;
              total_nxt = '0;
              gx_nxt    = '0;
              gy_nxt    = '0;
              gz_nxt    = '0;
              state_nxt = S_GEN;
            end
            ACT_GROW: begin
              pass_end_nxt = total_r;
              cursor_nxt   = '0;
              state_nxt    = below_target ? S_PASS : S_DONE;
            end
            ACT_READ: begin
              cv_nxt    = rd_in_range;
              state_nxt = S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_GEN: begin
        lfsr_nxt   = lf;
        grid_we    = 1'b1;
        grid_wdata = (lf[15:0] <= cfg.core_threshold);
        if (grid_wdata) begin
          list_we   = 1'b1;
          total_nxt = total_r + CW'(1);
        end
        // Raster order: x fastest, then y, then z.
        if (gx_r == LIM_X) begin
          gx_nxt = '0;
          if (gy_r == LIM_Y) begin
            gy_nxt = '0;
            if (gz_r == LIM_Z) begin
              gz_nxt    = '0;
              state_nxt = S_DONE;
            end else begin
              gz_nxt = gz_r + 8'd1;
            end
          end else begin
            gy_nxt = gy_r + 8'd1;
          end
        end else begin
          gx_nxt = gx_r + 8'd1;
        end
      end

      S_RD: begin
        cv_nxt    = cv_r & grid_rdata;
        state_nxt = S_DONE;
      end

      S_PASS: begin
        if (cursor_r < pass_end_r && below_target) begin
          state_nxt = S_LIST;
        end else begin
          // End of a pass: stop when nothing was added or the target is met.
          cursor_nxt   = '0;
          pass_end_nxt = total_r;
          if (total_r == pass_end_r || !below_target) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_LIST: begin
        cx_nxt    = 8'(list_rdata[XW-1:0]);
        cy_nxt    = 8'(list_rdata[XW +: YW]);
        cz_nxt    = 8'(list_rdata[XW+YW +: ZW]);
        nb_nxt    = '0;
        state_nxt = S_NB_RD;
      end

      S_NB_RD: begin
        grid_raddr = {nz[ZW-1:0], ny[YW-1:0], nx[XW-1:0]};
        na_nxt     = grid_raddr;
        state_nxt  = S_NB_CHK;
      end

      S_NB_CHK: begin
        grid_waddr = na_r;
        list_wdata = na_r;
        if (!grid_rdata) begin
          lfsr_nxt = lf;
          if (lf[PROB_W-1:0] < cfg.dir_prob[nb_r] && total_r < CELLS_C) begin
            grid_we    = 1'b1;
            grid_wdata = 1'b1;
            list_we    = 1'b1;
            total_nxt  = total_r + CW'(1);
          end
        end
        if (nb_r == NB_LAST) begin
          nb_nxt     = '0;
          cursor_nxt = cursor_r + CW'(1);
          state_nxt  = S_PASS;
        end else begin
          nb_nxt    = nb_r + NB_W'(1);
          state_nxt = S_NB_RD;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      total_r    <= '0;
      pass_end_r <= '0;
      cursor_r   <= '0;
      nb_r       <= '0;
      lfsr_r     <= 32'd1;
      cv_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      total_r    <= total_nxt;
      pass_end_r <= pass_end_nxt;
      cursor_r   <= cursor_nxt;
      nb_r       <= nb_nxt;
      lfsr_r     <= lfsr_nxt;
      cv_r       <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gx_r <= gx_nxt;
    gy_r <= gy_nxt;
    gz_r <= gz_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    na_r <= na_nxt;
  end

  assign cmd_ready          = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res.cell_value     = cv_r;
  assign res.filled_count   = total_k[COUNT_W-1:0];
  assign res.target_reached = !below_target;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CELLS_C)
    else $error("solid count exceeds the grid size");

  a_list_with_solid: assert property (@(posedge clk) disable iff (!rst_n)
    list_we |-> (grid_we && grid_wdata && list_waddr == total_r[AW-1:0]))
    else $error("list entry written without a new solid cell");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (total_r == $past(total_r)
                             || total_r == $past(total_r) + CW'(1)))
    else $error("solid count moved by more than one");

  a_cursor_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (cursor_r < pass_end_r))
    else $error("list read beyond the end of the pass");

endmodule

@@ hdl/stochastic_grid_growth_3d.sv @@
// Operation: a read looks up one grid cell through the registered grid read port; a generate
// writes one grid cell per cycle in raster order. A grow visits the 26 neighbours of each listed
// cell, one neighbour at a time on the single grid read port, pass after pass.
// One item at a time; the next is taken once the result is registered.
// Reset (synchronous, rst_n low) clears the count, the sequencer and the LFSR; the
// grid and list memories hold nothing defined until the first generate.
module stochastic_grid_growth_3d #(
  parameter int SIZE_X = sgg_pkg::DEF_SIZE_X,
  parameter int SIZE_Y = sgg_pkg::DEF_SIZE_Y,
  parameter int SIZE_Z = sgg_pkg::DEF_SIZE_Z
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // cell_x[4:0], cell_y[9:5], cell_z[14:10]
  input  logic [1:0]  in_tuser,    // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // cell_value[0], filled_count[16:1], target_reached[17]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import sgg_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  res_t  res;
  logic  res_valid, res_ready;
  logic  out_valid_r;
  res_t  out_r;

  sgg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign cmd.action = action_t'(in_tuser);
  assign cmd.cell_x = in_tdata[4:0];
  assign cmd.cell_y = in_tdata[9:5];
  assign cmd.cell_z = in_tdata[14:10];

  sgg_engine #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register frees the engine whenever it is empty or its held beat is being taken.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.target_reached, out_r.filled_count, out_r.cell_value};

endmodule
